// ===== sv/can_node_id_serial_tunnel_defines.svh =====
// Assertion helpers for the serial tunnel node.
// Each macro expects clock and reset in the scope where it is used.
`ifndef CAN_NODE_ID_SERIAL_TUNNEL_DEFINES_SVH
`define CAN_NODE_ID_SERIAL_TUNNEL_DEFINES_SVH

// Same-cycle implication.
`define CNST_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CNST_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/cnst_pkg.sv =====
`default_nettype none

package cnst_pkg;

   localparam int ID_W      = 11;
   localparam int LEN_W     = 4;
   localparam int DATA_W    = 64;
   localparam int UUID_W    = 48;
   localparam int NODE_W    = 16;
   localparam int CSR_IDX_W = 3;
   localparam int BYTES     = 8;

   localparam logic [ID_W-1:0]  ID_MASK  = 11'h7FF;
   localparam logic [LEN_W-1:0] LEN_MAX  = 4'd8;
   localparam logic [LEN_W-1:0] UUID_LEN = 4'd6;

   // request kinds
   localparam logic [1:0] REQ_RX_FRAME = 2'd0;
   localparam logic [1:0] REQ_TX_BYTE  = 2'd1;
   localparam logic [1:0] REQ_FLUSH    = 2'd2;

   // result actions
   localparam logic [2:0] ACT_UUID  = 3'd0;
   localparam logic [2:0] ACT_PONG  = 3'd1;
   localparam logic [2:0] ACT_DATA  = 3'd2;
   localparam logic [2:0] ACT_TO_SERIAL = 3'd3;
   localparam logic [2:0] ACT_RESET = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_QUERY_ID  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ASSIGN_ID = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLY_ID  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UUID      = 3'd3;

   localparam logic [ID_W-1:0]   QUERY_ID_RST  = 11'd801;
   localparam logic [ID_W-1:0]   ASSIGN_ID_RST = 11'd802;
   localparam logic [ID_W-1:0]   REPLY_ID_RST  = 11'd803;
   localparam logic [UUID_W-1:0] UUID_RST      = '0;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [ID_W-1:0]   rx_id;
      logic [LEN_W-1:0]  rx_len;
      logic [DATA_W-1:0] rx_data;
      logic [7:0]        tx_byte;
   } item_type;

   typedef struct packed {
      logic [2:0]        action;
      logic [ID_W-1:0]   frame_id;
      logic [LEN_W-1:0]  payload_len;
      logic [DATA_W-1:0] payload;
   } result_type;

   typedef struct packed {
      logic [ID_W-1:0]   query_id;
      logic [ID_W-1:0]   assign_id;
      logic [ID_W-1:0]   reply_id;
      logic [UUID_W-1:0] uuid;
   } cfg_type;

   // keep the low n bytes, clear the rest (n of 8 or more keeps all)
   function automatic logic [DATA_W-1:0] keep_bytes(input logic [DATA_W-1:0] v,
                                                    input logic [LEN_W-1:0]  n);
      logic [DATA_W-1:0] r;
      r = '0;
      for (int i = 0; i < BYTES; i++) begin
         if (LEN_W'(i) < n) begin
            r[8*i +: 8] = v[8*i +: 8];
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/can_node_id_serial_tunnel.sv =====
// Channel   Direction  Handshake              Word
// req       in         req_valid / req_stall  request type, rx frame, tx byte
// rsp       out        rsp_valid / rsp_stall  action, frame id, length, payload
// csr       in         csr_valid / csr_ready  register index, write data
//
// One word per cycle sustained while rsp_stall is low; a taken request passes the input register,
// the decode logic and then the result register before its result is on rsp.
// Reset is synchronous: node unassigned, tx buffer empty, registers at their defaults.
// A stalled result holds the request register; req_stall rises only while both are full.
// csr_ready is always high; a write is registered and seen on cfg from the next cycle.
`default_nettype none

module can_node_id_serial_tunnel (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_type,
   input  logic [cnst_pkg::ID_W-1:0]       req_rx_id,
   input  logic [cnst_pkg::LEN_W-1:0]      req_rx_len,
   input  logic [cnst_pkg::DATA_W-1:0]     req_rx_data,
   input  logic [7:0]                      req_tx_byte,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_action,
   output logic [cnst_pkg::ID_W-1:0]       rsp_frame_id,
   output logic [cnst_pkg::LEN_W-1:0]      rsp_payload_len,
   output logic [cnst_pkg::DATA_W-1:0]     rsp_payload,
   // register write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cnst_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cnst_pkg::UUID_W-1:0]     csr_wdata
);
   import cnst_pkg::*;

   cfg_type    cfg;
   item_type   req_item;
   item_type   item;
   result_type res;
   result_type rsp;
   logic       item_valid;
   logic       can_load;
   logic       fire;
   logic       hit;

   assign req_item.req_type = req_type;
   assign req_item.rx_id    = req_rx_id;
   assign req_item.rx_len   = req_rx_len;
   assign req_item.rx_data  = req_rx_data;
   assign req_item.tx_byte  = req_tx_byte;

   // the held word is decoded and retired when the result register can take it;
   // node state moves on the same edge
   assign fire = item_valid && can_load;

   cnst_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cnst_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .can_load   (can_load),
      .item_valid (item_valid),
      .item       (item)
   );

   cnst_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .item  (item),
      .fire  (fire),
      .hit   (hit),
      .res   (res)
   );

   // words that cause nothing (ignored frames, buffered bytes) load an empty slot
   cnst_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (fire && hit),
      .res       (res),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_action      = rsp.action;
   assign rsp_frame_id    = rsp.frame_id;
   assign rsp_payload_len = rsp.payload_len;
   assign rsp_payload     = rsp.payload;

endmodule

`default_nettype wire

// ===== sv/cnst_csr.sv =====
`default_nettype none

module cnst_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cnst_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cnst_pkg::UUID_W-1:0]   csr_wdata,
   output cnst_pkg::cfg_type             cfg
);
   import cnst_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_QUERY_ID:  cfg_in.query_id  = csr_wdata[ID_W-1:0];
            CSR_ASSIGN_ID: cfg_in.assign_id = csr_wdata[ID_W-1:0];
            CSR_REPLY_ID:  cfg_in.reply_id  = csr_wdata[ID_W-1:0];
            CSR_UUID:      cfg_in.uuid      = csr_wdata;
            default:       cfg_in = cfg_ff;   // unmapped index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.query_id  <= QUERY_ID_RST;
         cfg_ff.assign_id <= ASSIGN_ID_RST;
         cfg_ff.reply_id  <= REPLY_ID_RST;
         cfg_ff.uuid      <= UUID_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/cnst_in_stage.sv =====
`default_nettype none

module cnst_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  cnst_pkg::item_type req_item,
   input  logic               can_load,
   output logic               item_valid,
   output cnst_pkg::item_type item
);
   import cnst_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   logic     accept;
   item_type item_ff;

   // held word can only leave when the result side is free
   assign req_stall  = valid_ff && !can_load;
   assign accept     = req_valid && !req_stall;
   assign valid_in   = accept || (valid_ff && !can_load);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

endmodule

`default_nettype wire

// ===== sv/cnst_core.sv =====
`default_nettype none
`include "can_node_id_serial_tunnel_defines.svh"

module cnst_core (
   input  logic                 clock,
   input  logic                 reset,
   input  cnst_pkg::cfg_type    cfg,
   input  cnst_pkg::item_type   item,
   input  logic                 fire,
   output logic                 hit,
   output cnst_pkg::result_type res
);
   import cnst_pkg::*;

   logic [NODE_W-1:0] node_id_ff, node_id_in;
   logic [2:0]        txcnt_ff, txcnt_in;
   logic [7:0]        txq_ff [BYTES];
   logic              wr_en;
   logic [2:0]        wr_pos;

   logic              node_zero;
   logic              rid_is_node;
   logic [ID_W-1:0]   reply_id;
   logic [LEN_W-1:0]  len_sat;
   logic [DATA_W-1:0] txq_flat;
   logic [DATA_W-1:0] txq_full;

   assign node_zero   = (node_id_ff == '0);
   assign rid_is_node = ({{(NODE_W-ID_W){1'b0}}, item.rx_id} == node_id_ff);
   assign reply_id    = (node_id_ff[ID_W-1:0] + ID_W'(1)) & ID_MASK;
   assign len_sat     = (item.rx_len > LEN_MAX) ? LEN_MAX : item.rx_len;

   always_comb begin
      for (int i = 0; i < BYTES; i++) begin
         txq_flat[8*i +: 8] = txq_ff[i];
      end
      // last slot replaced by the incoming byte: the full frame case
      txq_full = {item.tx_byte, txq_flat[DATA_W-9:0]};
   end

   always_comb begin
      hit        = 1'b0;
      res        = '0;
      node_id_in = node_id_ff;
      txcnt_in   = txcnt_ff;
      wr_en      = 1'b0;
      wr_pos     = txcnt_ff;
      case (item.req_type)
         REQ_RX_FRAME: begin
            if (node_zero) begin
               if (item.rx_id == cfg.query_id && item.rx_len == '0) begin
                  hit             = 1'b1;
                  res.action      = ACT_UUID;
                  res.frame_id    = cfg.reply_id;
                  res.payload_len = UUID_LEN;
                  res.payload     = {{(DATA_W-UUID_W){1'b0}}, cfg.uuid};
               end else if (item.rx_id == cfg.assign_id &&
                            item.rx_data[DATA_W-1:NODE_W] == cfg.uuid) begin
                  node_id_in = item.rx_data[NODE_W-1:0];
               end
            end else if (rid_is_node) begin
               hit = 1'b1;
               if (item.rx_len == '0) begin
                  res.action   = ACT_PONG;
                  res.frame_id = reply_id;
               end else begin
                  res.action      = ACT_TO_SERIAL;
                  res.frame_id    = item.rx_id;
                  res.payload_len = len_sat;
                  res.payload     = keep_bytes(item.rx_data, len_sat);
               end
            end else if (item.rx_id == cfg.query_id && item.rx_len != '0 &&
                         item.rx_data[NODE_W-1:0] == node_id_ff) begin
               hit        = 1'b1;
               res.action = ACT_RESET;
               node_id_in = '0;
               txcnt_in   = '0;
            end
         end
         REQ_TX_BYTE: begin
            if (!node_zero) begin
               wr_en = 1'b1;
               if (txcnt_ff == 3'd7) begin
                  hit             = 1'b1;
                  res.action      = ACT_DATA;
                  res.frame_id    = reply_id;
                  res.payload_len = LEN_MAX;
                  res.payload     = txq_full;
                  txcnt_in        = '0;
               end else begin
                  txcnt_in = txcnt_ff + 3'd1;
               end
            end
         end
         REQ_FLUSH: begin
            if (!node_zero && txcnt_ff != '0) begin
               hit             = 1'b1;
               res.action      = ACT_DATA;
               res.frame_id    = reply_id;
               res.payload_len = {1'b0, txcnt_ff};
               res.payload     = keep_bytes(txq_flat, {1'b0, txcnt_ff});
               txcnt_in        = '0;
            end
         end
         default: begin
            hit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff <= '0;
         txcnt_ff   <= '0;
      end else if (fire) begin
         node_id_ff <= node_id_in;
         txcnt_ff   <= txcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && wr_en) begin
         txq_ff[wr_pos] <= item.tx_byte;
      end
   end

   `CNST_ASSERT_NXT(a_reset_clears, fire && hit && res.action == ACT_RESET,
                    node_id_ff == '0 && txcnt_ff == '0, "reset request left state behind")
   `CNST_ASSERT_IMP(a_unassigned_uuid_only, fire && hit && node_zero,
                    res.action == ACT_UUID, "unassigned node produced a non-uuid word")
   `CNST_ASSERT_NXT(a_full_frame_empties, fire && hit && res.action == ACT_DATA,
                    txcnt_ff == '0, "tx buffer not emptied after data frame")
   `CNST_ASSERT_IMP(a_len_bounded, hit, res.payload_len <= LEN_MAX,
                    "payload length above eight")

endmodule

`default_nettype wire

// ===== sv/cnst_out_stage.sv =====
`default_nettype none

module cnst_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  cnst_pkg::result_type res,
   output logic                 can_load,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cnst_pkg::result_type rsp
);
   import cnst_pkg::*;

   logic       valid_ff;
   result_type res_ff;

   assign can_load  = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp       = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (can_load) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (can_load && load) begin
         res_ff <= res;
      end
   end

endmodule

`default_nettype wire
